// File: hw/rtl/lpq_pkg.sv
// lpq_pkg: shared constants and types for the load pressure qualifier.
// Used by lpq_link_monitor, lpq_load_tracker and load_pressure_qualifier.
// No dependencies.
package lpq_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 5;

   localparam int unsigned FAIL_COUNT_MAX   = 200;
   localparam int unsigned FAIL_COUNT_LIMIT = 5;
   localparam int unsigned KPA_SCALE        = 20;

   localparam logic [15:0] LOAD_LIMIT_RESET   = 16'd0;
   localparam logic [15:0] MOVE_DELTA_RESET   = 16'(2 * KPA_SCALE);
   localparam logic [15:0] FAIL_TIMEOUT_RESET = 16'd2000;

   // configuration register indexes
   localparam logic [1:0] CSR_LOAD_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_MOVE_DELTA   = 2'd1;
   localparam logic [1:0] CSR_FAIL_TIMEOUT = 2'd2;

   // load classes
   localparam logic [1:0] CLASS_UNKNOWN = 2'd0;
   localparam logic [1:0] CLASS_LOADED  = 2'd1;
   localparam logic [1:0] CLASS_EMPTY   = 2'd2;

   typedef struct packed {
      logic        fork_moving;
      logic        carrying;
      logic        history_stable;
      logic [15:0] pressure_kpa;
   } track_result_type;

endpackage

// File: hw/rtl/load_pressure_qualifier.sv
// load_pressure_qualifier: top level of the fork load pressure qualifier.
// Depends on lpq_pkg, lpq_link_monitor and lpq_load_tracker.
// An accepted item passes from the input register through the combinational
// state update into the result register, which loads once it is empty or
// its result is taken. Throughput: one item per cycle while rsp_ready is
// held high, set by the combinational state update between the two registers.
// Reset (synchronous): clears the valid flags and tracking state and restores register defaults.
module load_pressure_qualifier
   import lpq_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_link_ok,
   input  logic [15:0] req_raw_reading,
   input  logic [31:0] req_now_ms,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_link_good,
   output logic        rsp_fork_moving,
   output logic        rsp_carrying,
   output logic [15:0] rsp_raw_echo,
   output logic [15:0] rsp_pressure_kpa,
   output logic        rsp_history_stable,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration registers
   logic [15:0] load_limit_ff;
   logic [15:0] move_delta_ff;
   logic [15:0] fail_timeout_ff;

   // input register
   logic        hold_valid_ff;
   logic        hold_link_ok_ff;
   logic [15:0] hold_raw_ff;
   logic [31:0] hold_now_ff;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_link_good_ff;
   logic        rsp_fork_moving_ff;
   logic        rsp_carrying_ff;
   logic [15:0] rsp_raw_echo_ff;
   logic [15:0] rsp_pressure_ff;
   logic        rsp_stable_ff;

   logic             advance;
   logic             link_lost;
   track_result_type track;

   // Advance the held item whenever the result register is empty or drains
   // this cycle; the input register refills in the same cycle.
   assign advance   = hold_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !hold_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Configuration: writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff   <= LOAD_LIMIT_RESET;
         move_delta_ff   <= MOVE_DELTA_RESET;
         fail_timeout_ff <= FAIL_TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LOAD_LIMIT:   load_limit_ff   <= csr_wdata;
            CSR_MOVE_DELTA:   move_delta_ff   <= csr_wdata;
            CSR_FAIL_TIMEOUT: fail_timeout_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register: take a new item whenever the slot is free or advancing.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_ready) begin
         hold_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hold_link_ok_ff <= req_link_ok;
         hold_raw_ff     <= req_raw_reading;
         hold_now_ff     <= req_now_ms;
      end
   end

   // Failure tracking updates on every processed item, lost or not.
   lpq_link_monitor u_link_monitor (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .link_ok         (hold_link_ok_ff),
      .now_ms          (hold_now_ff),
      .fail_timeout_ms (fail_timeout_ff),
      .link_lost       (link_lost)
   );

   // Pressure and load state freeze while the link is declared lost.
   lpq_load_tracker #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_load_tracker (
      .clock       (clock),
      .reset       (reset),
      .step        (advance && !link_lost),
      .raw_reading (hold_raw_ff),
      .load_limit  (load_limit_ff),
      .move_delta  (move_delta_ff),
      .result      (track)
   );

   // Result register: hold until taken; a lost link gives an all-zero item.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (link_lost) begin
            rsp_link_good_ff   <= 1'b0;
            rsp_fork_moving_ff <= 1'b0;
            rsp_carrying_ff    <= 1'b0;
            rsp_raw_echo_ff    <= 16'd0;
            rsp_pressure_ff    <= 16'd0;
            rsp_stable_ff      <= 1'b0;
         end else begin
            rsp_link_good_ff   <= 1'b1;
            rsp_fork_moving_ff <= track.fork_moving;
            rsp_carrying_ff    <= track.carrying;
            rsp_raw_echo_ff    <= hold_raw_ff;
            rsp_pressure_ff    <= track.pressure_kpa;
            rsp_stable_ff      <= track.history_stable;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_link_good      = rsp_link_good_ff;
   assign rsp_fork_moving    = rsp_fork_moving_ff;
   assign rsp_carrying       = rsp_carrying_ff;
   assign rsp_raw_echo       = rsp_raw_echo_ff;
   assign rsp_pressure_kpa   = rsp_pressure_ff;
   assign rsp_history_stable = rsp_stable_ff;

endmodule

// File: hw/rtl/lpq_link_monitor.sv
// lpq_link_monitor: failed-poll counter, first-failure timestamp and
// link-lost decision. Depends on lpq_pkg.
module lpq_link_monitor
   import lpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        link_ok,
   input  logic [31:0] now_ms,
   input  logic [15:0] fail_timeout_ms,
   output logic        link_lost
);

   logic [7:0]  fail_count_ff, fail_count_in;
   logic [31:0] first_fail_ff, first_fail_in;
   logic [31:0] elapsed;

   always_comb begin
      if (link_ok) begin
         fail_count_in = 8'd0;
      end else if (fail_count_ff < 8'(FAIL_COUNT_MAX)) begin
         fail_count_in = fail_count_ff + 8'd1;
      end else begin
         fail_count_in = fail_count_ff;
      end
      // latch the time of the first failure of a run
      if (!link_ok && fail_count_in == 8'd1) begin
         first_fail_in = now_ms;
      end else begin
         first_fail_in = first_fail_ff;
      end
      elapsed   = now_ms - first_fail_in;
      link_lost = (fail_count_in > 8'(FAIL_COUNT_LIMIT)) &&
                  (elapsed > {16'd0, fail_timeout_ms});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_count_ff <= 8'd0;
         first_fail_ff <= 32'd0;
      end else if (step) begin
         fail_count_ff <= fail_count_in;
         first_fail_ff <= first_fail_in;
      end
   end

endmodule

// File: hw/rtl/lpq_load_tracker.sv
// lpq_load_tracker: kPa scaling, motion detect, class history ring and
// carry flag. Depends on lpq_pkg.
module lpq_load_tracker
   import lpq_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [15:0]      raw_reading,
   input  logic [15:0]      load_limit,
   input  logic [15:0]      move_delta,
   output track_result_type result
);

   localparam int IDX_W = $clog2(HISTORY_DEPTH);

   logic [15:0]      prev_pressure_ff;
   logic [1:0]       history_ff [HISTORY_DEPTH];
   logic [1:0]       history_in [HISTORY_DEPTH];
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [1:0]       stable_class_ff;
   logic             carry_ff, carry_in;

   logic [15:0] pressure;
   logic [15:0] diff;
   logic [1:0]  cls;
   logic        stable;

   always_comb begin
      pressure = 16'(raw_reading * KPA_SCALE);
      diff = (pressure >= prev_pressure_ff) ? pressure - prev_pressure_ff
                                            : prev_pressure_ff - pressure;
      cls = (pressure > load_limit) ? CLASS_LOADED : CLASS_EMPTY;

      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         history_in[i] = (wr_idx_ff == IDX_W'(i)) ? cls : history_ff[i];
      end
      wr_idx_in = (wr_idx_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;

      stable = 1'b1;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
         if (history_in[i] != history_in[0]) begin
            stable = 1'b0;
         end
      end

      carry_in = carry_ff;
      if (stable) begin
         if (stable_class_ff == CLASS_LOADED) begin
            carry_in = 1'b1;
         end else if (history_in[0] == CLASS_EMPTY) begin
            carry_in = 1'b0;
         end
      end

      result.fork_moving    = (diff >= move_delta);
      result.carrying       = carry_in;
      result.history_stable = stable;
      result.pressure_kpa   = pressure;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pressure_ff <= 16'd0;
         wr_idx_ff        <= '0;
         stable_class_ff  <= CLASS_UNKNOWN;
         carry_ff         <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            history_ff[i] <= CLASS_UNKNOWN;
         end
      end else if (step) begin
         prev_pressure_ff <= pressure;
         wr_idx_ff        <= wr_idx_in;
         carry_ff         <= carry_in;
         if (stable) begin
            stable_class_ff <= history_in[0];
         end
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            history_ff[i] <= history_in[i];
         end
      end
   end

endmodule
